/* sv/rsch_pkg.sv */
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared types for the ray / sphere closest-hit unit.
// ----------------------------------------------------------------------------
package rsch_pkg;

   // One queued item, classified by the front part.
   typedef struct packed {
      logic [2:0][31:0] origin;
      logic [2:0][31:0] dir;
      logic [2:0][31:0] center;
      logic [30:0]      radius;
      logic             last;
      logic             test;
      logic [7:0]       pos;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OC,
      ST_HB,
      ST_OO,
      ST_RR,
      ST_DISC,
      ST_SQRT,
      ST_ROOT,
      ST_PNT,
      ST_DVLD,
      ST_DIV,
      ST_NDOT,
      ST_UPD,
      ST_FIN,
      ST_EMIT
   } state_type;

   localparam logic CSR_MIN_DISTANCE = 1'b0;
   localparam logic CSR_MAX_DISTANCE = 1'b1;

endpackage

/* sv/rsch_queue.sv */
// ----------------------------------------------------------------------------
// rsch_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module rsch_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsch_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output rsch_pkg::item_type pop_item
);

   rsch_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

/* sv/rsch_front.sv */
// ----------------------------------------------------------------------------
// rsch_front
// Accepts items, counts spheres per ray and marks which ones get tested.
// ----------------------------------------------------------------------------
module rsch_front #(
   parameter int MAX_SPHERES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rsch_pkg::item_type req_item,
   input  logic               q_full,
   output logic               q_push,
   output rsch_pkg::item_type q_item
);

   localparam int CW = $clog2(MAX_SPHERES + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          in_range;

   assign req_ready = ~q_full;
   assign q_push    = req_valid & ~q_full;
   assign in_range  = (count_ff < CW'(MAX_SPHERES));

   always_comb begin
      q_item      = req_item;
      q_item.test = in_range & (req_item.radius != '0);
      q_item.pos  = 8'(count_ff);
      if (req_item.last) begin
         count_in = '0;
      end else if (in_range) begin
         count_in = count_ff + CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (q_push) begin
         count_ff <= count_in;
      end
   end

endmodule

/* sv/rsch_back.sv */
// ----------------------------------------------------------------------------
// rsch_back
// Sequencer that intersects one sphere at a time on a shared multiplier,
// bit-serial square root and divider, and keeps the nearest hit.
// ----------------------------------------------------------------------------
module rsch_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  rsch_pkg::item_type q_item,
   output logic               q_pop,
   input  logic [30:0]        min_distance,
   input  logic [30:0]        max_distance,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_any_hit,
   output logic [30:0]        rsp_hit_distance,
   output logic [2:0][31:0]   rsp_point,
   output logic [2:0][31:0]   rsp_normal,
   output logic               rsp_front_face,
   output logic [7:0]         rsp_sphere_index
);

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return sat32(p >>> 16);
   endfunction

   rsch_pkg::state_type state_ff, state_in;
   rsch_pkg::item_type  cur_ff;

   logic [1:0]               idx_ff;
   logic signed [2:0][31:0]  oc_ff;
   logic signed [2:0][31:0]  pnt_ff;
   logic signed [2:0][31:0]  nrm_ff;
   logic signed [33:0]       acc_ff;
   logic signed [31:0]       hb_ff;
   logic signed [31:0]       oo_ff;
   logic signed [31:0]       cc_ff;
   logic [47:0]              xs_ff;
   logic [47:0]              rs_ff;
   logic [4:0]               k_ff;
   logic signed [31:0]       t_ff;
   logic [47:0]              num_ff;
   logic [31:0]              rem_ff;
   logic [5:0]               dcnt_ff;
   logic                     neg_ff;
   logic                     front_ff;

   logic                     found_ff;
   logic [30:0]              closest_ff;
   logic [2:0][31:0]         best_point_ff;
   logic [2:0][31:0]         best_normal_ff;
   logic                     best_front_ff;
   logic [7:0]               best_index_ff;

   logic                     rsp_valid_ff;

   logic signed [31:0] mul_a, mul_b, mul_q;
   logic signed [33:0] acc_sum;
   logic signed [31:0] disc;
   logic [47:0]        bitv, trial;
   logic signed [33:0] t1, t2, lo, hi;
   logic               t1_ok, t2_ok;
   logic signed [31:0] pc;
   logic [31:0]        rem_sh;
   logic               rem_ge;
   logic               out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Operand select for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         rsch_pkg::ST_HB: begin
            mul_a = oc_ff[idx_ff];
            mul_b = $signed(cur_ff.dir[idx_ff]);
         end
         rsch_pkg::ST_OO: begin
            mul_a = oc_ff[idx_ff];
            mul_b = oc_ff[idx_ff];
         end
         rsch_pkg::ST_RR: begin
            mul_a = $signed({1'b0, cur_ff.radius});
            mul_b = $signed({1'b0, cur_ff.radius});
         end
         rsch_pkg::ST_DISC: begin
            mul_a = hb_ff;
            mul_b = hb_ff;
         end
         rsch_pkg::ST_PNT: begin
            mul_a = $signed(cur_ff.dir[idx_ff]);
            mul_b = t_ff;
         end
         rsch_pkg::ST_NDOT: begin
            mul_a = $signed(cur_ff.dir[idx_ff]);
            mul_b = nrm_ff[idx_ff];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_q   = qmul(mul_a, mul_b);
   assign acc_sum = ((idx_ff == 2'd0) ? 34'sd0 : acc_ff) + 34'(mul_q);
   assign disc    = sat32(64'(mul_q) - 64'(cc_ff));

   assign bitv  = 48'(1) << {k_ff, 1'b0};
   assign trial = rs_ff + bitv;

   assign t1    = -34'(hb_ff) - $signed({10'b0, rs_ff[23:0]});
   assign t2    = -34'(hb_ff) + $signed({10'b0, rs_ff[23:0]});
   assign lo    = $signed({3'b0, min_distance});
   assign hi    = found_ff ? $signed({3'b0, closest_ff}) : $signed({3'b0, max_distance});
   assign t1_ok = (t1 >= lo) && (t1 <= hi);
   assign t2_ok = (t2 >= lo) && (t2 <= hi);

   assign pc     = sat32(64'($signed(pnt_ff[idx_ff])) -
                         64'($signed(cur_ff.center[idx_ff])));
   assign rem_sh = {rem_ff[30:0], num_ff[47]};
   assign rem_ge = (rem_sh >= {1'b0, cur_ff.radius});

   // Next state and handshakes.
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         rsch_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               state_in = q_item.test ? rsch_pkg::ST_OC : rsch_pkg::ST_FIN;
            end
         end
         rsch_pkg::ST_OC:   state_in = rsch_pkg::ST_HB;
         rsch_pkg::ST_HB:   if (idx_ff == 2'd2) state_in = rsch_pkg::ST_OO;
         rsch_pkg::ST_OO:   if (idx_ff == 2'd2) state_in = rsch_pkg::ST_RR;
         rsch_pkg::ST_RR:   state_in = rsch_pkg::ST_DISC;
         rsch_pkg::ST_DISC: state_in = disc[31] ? rsch_pkg::ST_FIN : rsch_pkg::ST_SQRT;
         rsch_pkg::ST_SQRT: if (k_ff == 5'd0) state_in = rsch_pkg::ST_ROOT;
         rsch_pkg::ST_ROOT: state_in = (t1_ok | t2_ok) ? rsch_pkg::ST_PNT : rsch_pkg::ST_FIN;
         rsch_pkg::ST_PNT:  if (idx_ff == 2'd2) state_in = rsch_pkg::ST_DVLD;
         rsch_pkg::ST_DVLD: state_in = rsch_pkg::ST_DIV;
         rsch_pkg::ST_DIV: begin
            if (dcnt_ff == 6'd47) begin
               state_in = (idx_ff == 2'd2) ? rsch_pkg::ST_NDOT : rsch_pkg::ST_DVLD;
            end
         end
         rsch_pkg::ST_NDOT: if (idx_ff == 2'd2) state_in = rsch_pkg::ST_UPD;
         rsch_pkg::ST_UPD:  state_in = rsch_pkg::ST_FIN;
         rsch_pkg::ST_FIN:  state_in = cur_ff.last ? rsch_pkg::ST_EMIT : rsch_pkg::ST_IDLE;
         rsch_pkg::ST_EMIT: if (out_free) state_in = rsch_pkg::ST_IDLE;
         default:           state_in = rsch_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsch_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_item;
      unique case (state_ff)
         rsch_pkg::ST_OC: begin
            for (int i = 0; i < 3; i++) begin
               oc_ff[i] <= sat32(64'($signed(cur_ff.origin[i])) -
                                 64'($signed(cur_ff.center[i])));
            end
            idx_ff <= 2'd0;
         end
         rsch_pkg::ST_HB, rsch_pkg::ST_OO: begin
            acc_ff <= acc_sum;
            idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               if (state_ff == rsch_pkg::ST_HB) hb_ff <= sat32(64'(acc_sum));
               else                             oo_ff <= sat32(64'(acc_sum));
            end
         end
         rsch_pkg::ST_RR: cc_ff <= sat32(64'(oo_ff) - 64'(mul_q));
         rsch_pkg::ST_DISC: begin
            xs_ff <= {disc[31:0], 16'b0};
            rs_ff <= '0;
            k_ff  <= 5'd23;
         end
         rsch_pkg::ST_SQRT: begin
            if (xs_ff >= trial) begin
               xs_ff <= xs_ff - trial;
               rs_ff <= (rs_ff >> 1) + bitv;
            end else begin
               rs_ff <= rs_ff >> 1;
            end
            k_ff <= k_ff - 5'd1;
         end
         rsch_pkg::ST_ROOT: begin
            t_ff   <= t1_ok ? t1[31:0] : t2[31:0];
            idx_ff <= 2'd0;
         end
         rsch_pkg::ST_PNT: begin
            pnt_ff[idx_ff] <= sat32(64'($signed(cur_ff.origin[idx_ff])) + 64'(mul_q));
            idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
         end
         rsch_pkg::ST_DVLD: begin
            neg_ff  <= pc[31];
            num_ff  <= {(pc[31] ? 32'(-64'(pc)) : 32'(pc)), 16'b0};
            rem_ff  <= '0;
            dcnt_ff <= 6'd0;
         end
         rsch_pkg::ST_DIV: begin
            rem_ff  <= rem_ge ? rem_sh - {1'b0, cur_ff.radius} : rem_sh;
            num_ff  <= {num_ff[46:0], rem_ge};
            dcnt_ff <= dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd47) begin
               // Quotient is complete after this shift; sign and saturate.
               if (neg_ff) begin
                  nrm_ff[idx_ff] <= ({num_ff[46:0], rem_ge} > 48'h80000000) ?
                                    32'sh80000000 : 32'(-{num_ff[46:0], rem_ge});
               end else begin
                  nrm_ff[idx_ff] <= ({num_ff[46:0], rem_ge} > 48'h7FFFFFFF) ?
                                    32'sh7FFFFFFF : 32'({num_ff[46:0], rem_ge});
               end
               idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            end
         end
         rsch_pkg::ST_NDOT: begin
            acc_ff <= acc_sum;
            idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            if (idx_ff == 2'd2) front_ff <= acc_sum[33];
         end
         default: begin
         end
      endcase
   end

   // Running nearest-hit state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff       <= 1'b0;
         closest_ff     <= '0;
         best_point_ff  <= '0;
         best_normal_ff <= '0;
         best_front_ff  <= 1'b0;
         best_index_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != rsch_pkg::ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == rsch_pkg::ST_UPD) begin
            found_ff      <= 1'b1;
            closest_ff    <= t_ff[30:0];
            best_point_ff <= pnt_ff;
            best_front_ff <= front_ff;
            best_index_ff <= cur_ff.pos;
            for (int i = 0; i < 3; i++) begin
               if (front_ff) best_normal_ff[i] <= nrm_ff[i];
               else if (nrm_ff[i] == 32'sh80000000) best_normal_ff[i] <= 32'sh7FFFFFFF;
               else best_normal_ff[i] <= -nrm_ff[i];
            end
         end
         if (state_ff == rsch_pkg::ST_EMIT && out_free) begin
            rsp_valid_ff   <= 1'b1;
            found_ff       <= 1'b0;
            closest_ff     <= '0;
            best_point_ff  <= '0;
            best_normal_ff <= '0;
            best_front_ff  <= 1'b0;
            best_index_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rsch_pkg::ST_EMIT && out_free) begin
         rsp_any_hit      <= found_ff;
         rsp_hit_distance <= closest_ff;
         rsp_point        <= best_point_ff;
         rsp_normal       <= best_normal_ff;
         rsp_front_face   <= best_front_ff;
         rsp_sphere_index <= best_index_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/ray_sphere_closest_hit.sv */
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit
// Ray / sphere nearest-hit unit, signed Q16.16 with saturating arithmetic.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            moves
//  req_     in         req_valid/req_ready  one ray plus one sphere
//  rsp_     out        rsp_valid/rsp_ready  nearest hit of a ray, on its last item
//  csr_     in         csr_wr_en            min / max distance
//
//  Items are worked one at a time by the back sequencer; the front queues up
//  to two more. An untested sphere, a negative discriminant or roots outside
//  the range end an item early; a hit runs 24 square-root steps and three
//  normal divisions. A last item then passes through an emit state.
//  Reset is synchronous and clears all control and running state.
//  A stalled rsp_ready holds the result and backs up into the queue.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit #(
   parameter int MAX_SPHERES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_origin_x,
   input  logic [31:0] req_origin_y,
   input  logic [31:0] req_origin_z,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   input  logic [31:0] req_dir_z,
   input  logic [31:0] req_center_x,
   input  logic [31:0] req_center_y,
   input  logic [31:0] req_center_z,
   input  logic [30:0] req_sphere_radius,
   input  logic        req_last_sphere,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_any_hit,
   output logic [30:0] rsp_hit_distance,
   output logic [31:0] rsp_point_x,
   output logic [31:0] rsp_point_y,
   output logic [31:0] rsp_point_z,
   output logic [31:0] rsp_normal_x,
   output logic [31:0] rsp_normal_y,
   output logic [31:0] rsp_normal_z,
   output logic        rsp_front_face,
   output logic [7:0]  rsp_sphere_index
);

   logic [30:0] min_distance_ff;
   logic [30:0] max_distance_ff;

   rsch_pkg::item_type req_item, q_in_item, q_out_item;
   logic q_push, q_full, q_pop, q_not_empty;
   logic [2:0][31:0] point, normal;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff <= 31'd66;
         max_distance_ff <= 31'h7FFFFFFF;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rsch_pkg::CSR_MIN_DISTANCE: min_distance_ff <= csr_wdata;
            rsch_pkg::CSR_MAX_DISTANCE: max_distance_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_item.origin = {req_origin_z, req_origin_y, req_origin_x};
      req_item.dir    = {req_dir_z, req_dir_y, req_dir_x};
      req_item.center = {req_center_z, req_center_y, req_center_x};
      req_item.radius = req_sphere_radius;
      req_item.last   = req_last_sphere;
      req_item.test   = 1'b0;
      req_item.pos    = '0;
   end

   rsch_front #(.MAX_SPHERES(MAX_SPHERES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   rsch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (q_out_item)
   );

   rsch_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_item           (q_out_item),
      .q_pop            (q_pop),
      .min_distance     (min_distance_ff),
      .max_distance     (max_distance_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_any_hit      (rsp_any_hit),
      .rsp_hit_distance (rsp_hit_distance),
      .rsp_point        (point),
      .rsp_normal       (normal),
      .rsp_front_face   (rsp_front_face),
      .rsp_sphere_index (rsp_sphere_index)
   );

   assign rsp_point_x  = point[0];
   assign rsp_point_y  = point[1];
   assign rsp_point_z  = point[2];
   assign rsp_normal_x = normal[0];
   assign rsp_normal_y = normal[1];
   assign rsp_normal_z = normal[2];

endmodule

/* sv/rsch_checker.sv */
// ----------------------------------------------------------------------------
// rsch_checker
// Port-level checks for the ray / sphere closest-hit unit.
// ----------------------------------------------------------------------------
module rsch_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_any_hit,
   input logic [30:0] rsp_hit_distance,
   input logic        rsp_front_face,
   input logic [7:0]  rsp_sphere_index,
   input logic [31:0] rsp_normal_x
);

   // No result survives a reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled item.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_distance)
                                 && $stable(rsp_normal_x))
      else $error("stalled result changed");

   // A miss reports all-zero hit fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_any_hit |-> rsp_hit_distance == '0 && !rsp_front_face
                                    && rsp_sphere_index == '0 && rsp_normal_x == '0)
      else $error("miss with nonzero fields");

endmodule

bind ray_sphere_closest_hit rsch_checker u_rsch_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit testbench
// Drives rays and spheres through the closest-hit unit, predicts the
// nearest hit of each ray in Q16.16 and checks every result field.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic [31:0] org[3];
      logic [31:0] dir[3];
      logic [31:0] ctr[3];
      logic [30:0] rad;
      logic        last;
   } sphere_item_type;

   typedef struct {
      logic        any;
      logic [30:0] span;
      logic [31:0] pnt[3];
      logic [31:0] nrm[3];
      logic        front;
      logic [7:0]  idx;
   } hit_result_type;

   class hit_scoreboard;
      longint            min_dist, max_dist, closest_t;
      bit                found, best_front;
      longint            best_pnt[3], best_nrm[3];
      int unsigned       best_idx, count;
      hit_result_type    expected[$];
      int                errors;

      function new();
         min_dist = 66;
         max_dist = 64'h7FFF_FFFF;
         errors = 0;
         clear_ray();
      endfunction

      function void clear_ray();
         closest_t = max_dist;
         found = 0;
         best_front = 0;
         best_idx = 0;
         count = 0;
         for (int i = 0; i < 3; i++) begin
            best_pnt[i] = 0;
            best_nrm[i] = 0;
         end
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint qmul(longint a, longint b);
         longint p;
         p = a * b;
         return sat(p >>> 16);
      endfunction

      function longint qdot(longint a[3], longint b[3]);
         return sat(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
      endfunction

      function longint floor_sqrt(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return longint'(r);
      endfunction

      function void write_reg(logic idx, logic [30:0] val);
         if (idx == rsch_pkg::CSR_MIN_DISTANCE) begin
            min_dist = longint'(val);
         end else begin
            max_dist = longint'(val);
            if (!found) closest_t = max_dist;
         end
      endfunction

      function void trace_sphere(sphere_item_type it);
         longint o[3], d[3], c[3], oc[3], p[3], n[3];
         longint r, hb, cc, disc, s, t, lo, hi;
         bit front;
         r = longint'(it.rad);
         if (r == 0) return;
         for (int i = 0; i < 3; i++) begin
            o[i] = longint'($signed(it.org[i]));
            d[i] = longint'($signed(it.dir[i]));
            c[i] = longint'($signed(it.ctr[i]));
            oc[i] = sat(o[i] - c[i]);
         end
         hb = qdot(oc, d);
         cc = sat(qdot(oc, oc) - qmul(r, r));
         disc = sat(qmul(hb, hb) - cc);
         if (disc < 0) return;
         s = floor_sqrt(longint'(disc) << 16);
         lo = min_dist;
         hi = found ? closest_t : max_dist;
         t = -hb - s;
         if (t < lo || t > hi) begin
            t = -hb + s;
            if (t < lo || t > hi) return;
         end
         for (int i = 0; i < 3; i++) begin
            p[i] = sat(o[i] + qmul(d[i], t));
            n[i] = sat((sat(p[i] - c[i]) * 65536) / r);
         end
         front = qdot(d, n) < 0;
         for (int i = 0; i < 3; i++) begin
            best_pnt[i] = p[i];
            best_nrm[i] = front ? n[i] : sat(-n[i]);
         end
         closest_t = t;
         found = 1;
         best_front = front;
         best_idx = count & 8'hFF;
      endfunction

      function void note_item(sphere_item_type it);
         hit_result_type h;
         if (count < 256) begin
            trace_sphere(it);
            count++;
         end
         if (!it.last) return;
         h.any = found;
         h.span = found ? closest_t[30:0] : '0;
         for (int i = 0; i < 3; i++) begin
            h.pnt[i] = found ? best_pnt[i][31:0] : '0;
            h.nrm[i] = found ? best_nrm[i][31:0] : '0;
         end
         h.front = found && best_front;
         h.idx = found ? best_idx[7:0] : '0;
         expected = {expected, h};
         clear_ray();
      endfunction

      function void check_hit(hit_result_type a);
         hit_result_type e;
         bit bad;
         if (expected.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: any_hit=%0b dist=%h", a.any, a.span);
            return;
         end
         e = expected.pop_front();
         bad = (a.any !== e.any) || (a.span !== e.span) || (a.front !== e.front)
               || (a.idx !== e.idx);
         for (int i = 0; i < 3; i++)
            bad = bad || (a.pnt[i] !== e.pnt[i]) || (a.nrm[i] !== e.nrm[i]);
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp: hit=%0b t=%h p=%h %h %h n=%h %h %h ff=%0b idx=%0d",
                        e.any, e.span, e.pnt[0], e.pnt[1], e.pnt[2],
                        e.nrm[0], e.nrm[1], e.nrm[2], e.front, e.idx);
               $display("         got: hit=%0b t=%h p=%h %h %h n=%h %h %h ff=%0b idx=%0d",
                        a.any, a.span, a.pnt[0], a.pnt[1], a.pnt[2],
                        a.nrm[0], a.nrm[1], a.nrm[2], a.front, a.idx);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic        csr_index = rsch_pkg::CSR_MIN_DISTANCE;
   logic [30:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic [31:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [31:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [30:0] req_sphere_radius = '0;
   logic        req_last_sphere = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_any_hit;
   logic [30:0] rsp_hit_distance;
   logic [31:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic [31:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic        rsp_front_face;
   logic [7:0]  rsp_sphere_index;

   localparam int SETTLE = 1000;
   localparam logic [31:0] ONE = 32'h0001_0000;

   hit_scoreboard hits = new();
   int send_gap_pct = 0;
   int stall_pct = 0;

   ray_sphere_closest_hit dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      hit_result_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         a.any = rsp_any_hit;
         a.span = rsp_hit_distance;
         a.pnt[0] = rsp_point_x;
         a.pnt[1] = rsp_point_y;
         a.pnt[2] = rsp_point_z;
         a.nrm[0] = rsp_normal_x;
         a.nrm[1] = rsp_normal_y;
         a.nrm[2] = rsp_normal_z;
         a.front = rsp_front_face;
         a.idx = rsp_sphere_index;
         hits.check_hit(a);
      end
   end

   task automatic send_sphere(sphere_item_type it);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_origin_x <= it.org[0];
      req_origin_y <= it.org[1];
      req_origin_z <= it.org[2];
      req_dir_x <= it.dir[0];
      req_dir_y <= it.dir[1];
      req_dir_z <= it.dir[2];
      req_center_x <= it.ctr[0];
      req_center_y <= it.ctr[1];
      req_center_z <= it.ctr[2];
      req_sphere_radius <= it.rad;
      req_last_sphere <= it.last;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      hits.note_item(it);
   endtask

   // hold until the unit is quiet: results drained, then a settle wait
   task automatic drain();
      req_valid <= 0;
      while (hits.expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_range(logic [30:0] lo, logic [30:0] hi);
      csr_wr_en <= 1;
      csr_index <= rsch_pkg::CSR_MIN_DISTANCE;
      csr_wdata <= lo;
      hits.write_reg(rsch_pkg::CSR_MIN_DISTANCE, lo);
      @(posedge clock);
      csr_index <= rsch_pkg::CSR_MAX_DISTANCE;
      csr_wdata <= hi;
      hits.write_reg(rsch_pkg::CSR_MAX_DISTANCE, hi);
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic sphere_item_type axis_item(int cx, int cz, int unsigned rad, bit last);
      sphere_item_type it;
      for (int i = 0; i < 3; i++) begin
         it.org[i] = '0;
         it.dir[i] = '0;
      end
      it.dir[2] = ONE;
      it.ctr[0] = cx * 65536;
      it.ctr[1] = '0;
      it.ctr[2] = cz * 65536;
      it.rad = 31'(rad);
      it.last = last;
      return it;
   endfunction

   function automatic real rnd(real lo, real hi);
      return lo + (hi - lo) * ($urandom_range(1000000) / 1000000.0);
   endfunction

   function automatic sphere_item_type noise_item();
      sphere_item_type it;
      for (int i = 0; i < 3; i++) begin
         it.org[i] = $urandom;
         it.dir[i] = $urandom;
         it.ctr[i] = $urandom;
      end
      it.rad = 31'($urandom);
      it.last = 1'($urandom_range(1));
      return it;
   endfunction

   // one well-formed ray: unit direction, spheres scattered along it
   task automatic send_ray(int unsigned spheres);
      real o[3], u[3], len, span, rad;
      sphere_item_type it;
      for (int i = 0; i < 3; i++) begin
         o[i] = rnd(-200.0, 200.0);
         u[i] = rnd(-1.0, 1.0);
      end
      len = $sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
      if (len < 0.01) begin
         u[0] = 1.0;
         len = 1.0;
      end
      for (int i = 0; i < 3; i++) begin
         it.org[i] = $rtoi(o[i] * 65536.0);
         it.dir[i] = $rtoi(u[i] / len * 65536.0);
      end
      for (int k = 0; k < spheres; k++) begin
         rad = rnd(0.01, 30.0);
         span = rnd(-20.0, 300.0);
         for (int i = 0; i < 3; i++)
            it.ctr[i] = $rtoi((o[i] + u[i] / len * span + rnd(-1.5, 1.5) * rad) * 65536.0);
         it.rad = 31'($rtoi(rad * 65536.0));
         it.last = (k == spheres - 1);
         send_sphere(it);
      end
   endtask

   // a ray longer than the sphere list: entries past the end are not tested
   task automatic send_long_ray();
      for (int k = 0; k < 270; k++) begin
         if (k == 255) send_sphere(axis_item(0, 10, ONE, 0));
         else if (k == 262) send_sphere(axis_item(0, 5, ONE, 0));
         else send_sphere(axis_item(100, 10, ONE, k == 269));
      end
   endtask

   initial begin
      sphere_item_type it;
      logic [30:0] lo_tab[8], hi_tab[8];
      lo_tab = '{31'd0, 31'd66, 31'd0, 31'h7FFF_FFFF, 31'd0, 31'h0001_0000,
                 31'h7FFF_FFFF, 31'd0};
      hi_tab = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF,
                 31'h0064_0000, 31'h00C8_0000, 31'd0, 31'h7FFF_FFFF};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: plain hit, inside hit, miss, tangent, zero radius
      send_sphere(axis_item(0, 10, ONE, 1));
      send_sphere(axis_item(0, 0, 5 * ONE, 1));
      send_sphere(axis_item(10, 10, ONE, 1));
      send_sphere(axis_item(1, 10, ONE, 1));
      send_sphere(axis_item(0, 10, 0, 1));
      // equal distance: the later sphere wins
      send_sphere(axis_item(0, 10, ONE, 0));
      send_sphere(axis_item(0, 10, ONE, 0));
      send_sphere(axis_item(50, 10, ONE, 1));
      // field extremes
      for (int i = 0; i < 3; i++) begin
         it.org[i] = 32'h7FFF_FFFF;
         it.dir[i] = 32'h7FFF_FFFF;
         it.ctr[i] = 32'h8000_0000;
      end
      it.rad = 31'h7FFF_FFFF;
      it.last = 1;
      send_sphere(it);
      for (int i = 0; i < 3; i++) begin
         it.org[i] = 32'h8000_0000;
         it.dir[i] = 32'h8000_0000;
         it.ctr[i] = 32'h7FFF_FFFF;
      end
      it.rad = 31'd1;
      send_sphere(it);
      it.rad = 31'd0;
      for (int i = 0; i < 3; i++) it.ctr[i] = 32'h8000_0000;
      send_sphere(it);
      // register write inside a ray, before any hit is stored
      send_sphere(axis_item(40, 10, ONE, 0));
      drain();
      set_range(31'd0, 31'h0014_0000);
      send_sphere(axis_item(0, 30, ONE, 0));
      send_sphere(axis_item(0, 10, ONE, 1));

      for (int ph = 0; ph < 8; ph++) begin
         int n;
         drain();
         set_range(lo_tab[ph], hi_tab[ph]);
         send_gap_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 47 : 11) : 0;
         stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 47 : 11) : 0;
         if (ph == 1) send_long_ray();
         n = 0;
         while (n < 60) begin
            if ($urandom_range(99) < 15) begin
               send_sphere(noise_item());
               n++;
            end else begin
               int k;
               k = $urandom_range(1, 6);
               send_ray(k);
               n += k;
            end
         end
      end

      req_valid <= 0;
      while (hits.expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (hits.errors == 0)
         $display("ray_sphere_closest_hit test passed");
      else
         $display("ray_sphere_closest_hit test failed");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("ray_sphere_closest_hit test failed");
      $finish;
   end

endmodule

/* ray_sphere_closest_hit.f */
sv/rsch_pkg.sv
sv/rsch_queue.sv
sv/rsch_front.sv
sv/rsch_back.sv
sv/ray_sphere_closest_hit.sv
sv/rsch_checker.sv
test/tb.sv
